FILE: hdl/wgm_pkg.sv
// shared types and constants for the wildcard glob matcher
// no dependencies; imported by wgm_cell and wildcard_glob_matcher
package wgm_pkg;

  // pattern capacity in bytes; the row has one extra cell for the end position
  localparam int MAX_PATTERN = 32;
  localparam int NUM_CELLS   = MAX_PATTERN + 1;

  // pattern wildcards
  localparam logic [7:0] CHAR_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_ANY_RUN = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       accept;
    func_t      func;
    logic [7:0] char_value;
  } cell_ctl_t;

  // fixed role of a cell in the row
  typedef struct packed {
    logic home;      // position zero, active after reset
    logic writable;  // may hold a pattern byte
  } cell_pos_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic valid;  // cell i holds a pattern byte
    logic move;   // cell i consumes the text byte and hands its token on
    logic close;  // cell i is active next and holds a star
  } link_t;

endpackage

FILE: hdl/wildcard_glob_matcher.sv
// wildcard glob matcher top level: row of wgm_cell positions and the result register
// depends on wgm_pkg and wgm_cell
//
// Glob matcher for '*' (any run, the empty run included) and '?' (any single byte);
// every other byte must match exactly, case respected. Each input word carries a
// command in s_tuser and a byte in s_tdata: clear pattern, append pattern byte,
// text byte, or end of text. Up to MAX_PATTERN pattern bytes are kept, one per cell
// of a row of MAX_PATTERN+1 cells; further bytes are dropped and an overflow flag is
// raised until the next clear. Each cell holds one pattern byte and one active token;
// a text byte moves all tokens at once, each cell handing its token to its right
// neighbor, and star closure ripples down the row like a carry chain. Only the end
// of text word yields an output word (matched in bit 0, overflow in bit 1), after
// which the matcher re-arms for the next text; a clear or an append also re-arms.
// One word is taken per cycle, every word type alike, while no result waits; the
// token update with its ripple through the row is what sets that rate. A result
// appears in the cycle after its end of text word and sits in an output register;
// while that result word waits for m_tready, s_tready is low and no input word of
// any type is taken, and input resumes in the same cycle the result word is taken.
module wildcard_glob_matcher import wgm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_value
  input  logic [1:0] s_tuser,   // [1:0] func
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  logic      s_accept;
  func_t     func;
  cell_ctl_t ctl;

  link_t     links [NUM_CELLS];
  link_t     tail_link;
  logic [NUM_CELLS-1:0] end_hits;
  logic [NUM_CELLS-1:0] valid_vec;

  logic      overflow_flag;
  logic      pattern_full;
  logic      matched_q;
  logic      overflow_q;

  // the result register frees up when its word is taken
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign func     = func_t'(s_tuser);

  assign ctl.accept     = s_accept;
  assign ctl.func       = func;
  assign ctl.char_value = s_tdata;

  // left edge of the row: position zero is seeded on every re-arm
  assign links[0].valid = 1'b1;
  assign links[0].move  = 1'b0;
  assign links[0].close = (func != FUNC_TEXT);

  genvar gi;
  generate
    for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      cell_pos_t pos;
      link_t     link_out;
      assign pos.home     = (gi == 0);
      assign pos.writable = (gi < MAX_PATTERN);
      wgm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .pos      (pos),
        .link_in  (links[gi]),
        .link_out (link_out),
        .end_hit  (end_hits[gi])
      );
      assign valid_vec[gi] = link_out.valid;
      if (gi < NUM_CELLS - 1) begin : g_next
        assign links[gi+1] = link_out;
      end else begin : g_tail
        assign tail_link = link_out;
      end
    end
  endgenerate

  // store is full once the last pattern cell holds a byte
  assign pattern_full = valid_vec[MAX_PATTERN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_flag <= 1'b0;
    end else if (s_accept) begin
      if (func == FUNC_CLEAR) begin
        overflow_flag <= 1'b0;
      end else if ((func == FUNC_APPEND) && pattern_full) begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept && (func == FUNC_END)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && (func == FUNC_END)) begin
      matched_q  <= |end_hits;
      overflow_q <= overflow_flag;
    end
  end

  assign m_tdata = {6'd0, overflow_q, matched_q};

  // filled cells always form a prefix of the row
  assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + NUM_CELLS'(1)) & valid_vec) == '0)
    else $error("pattern cells not filled as a prefix");

  // the end-position cell never takes a byte, so it never hands anything on
  assert property (@(posedge clk) disable iff (rst)
    !tail_link.valid && !tail_link.move && !tail_link.close)
    else $error("end-position cell holds a pattern byte");

  // a clear empties the row and drops the overflow flag
  assert property (@(posedge clk) disable iff (rst)
    s_accept && (func == FUNC_CLEAR) |=> (valid_vec == '0) && !overflow_flag)
    else $error("clear did not empty the pattern");

  // every end of text word produces a result word
  assert property (@(posedge clk) disable iff (rst)
    s_accept && (func == FUNC_END) |=> m_tvalid)
    else $error("end of text without a result");

endmodule

FILE: hdl/wgm_cell.sv
// one pattern position: stored byte, fill bit and active token
// depends on wgm_pkg
module wgm_cell import wgm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  cell_pos_t pos,
  input  link_t     link_in,
  output link_t     link_out,
  output logic      end_hit
);

  logic [7:0] pat;
  logic       valid;
  logic       active;

  logic       write_here;
  logic       valid_next;
  logic [7:0] pat_next;
  logic       star_next;
  logic       star_now;
  logic       stay;
  logic       active_next;

  assign write_here = (ctl.func == FUNC_APPEND) && pos.writable && !valid && link_in.valid;
  assign star_now   = valid && (pat == CHAR_ANY_RUN);
  assign stay       = active && star_now;

  always_comb begin
    valid_next = valid;
    pat_next   = pat;
    if (ctl.func == FUNC_CLEAR) begin
      valid_next = 1'b0;
    end else if (write_here) begin
      valid_next = 1'b1;
      pat_next   = ctl.char_value;
    end
    star_next = valid_next && (pat_next == CHAR_ANY_RUN);
    // text byte advances tokens, everything else re-arms from position zero
    if (ctl.func == FUNC_TEXT) begin
      active_next = link_in.close || link_in.move || stay;
    end else begin
      active_next = link_in.close;
    end
  end

  assign link_out.valid = valid;
  assign link_out.move  = (ctl.func == FUNC_TEXT) && active && valid && !star_now &&
                          ((pat == CHAR_ANY_ONE) || (pat == ctl.char_value));
  assign link_out.close = active_next && star_next;

  // hit when this cell is active and sits at the pattern end: the previous one is filled and it is not
  assign end_hit = active && link_in.valid && !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      active <= pos.home;
    end else if (ctl.accept) begin
      valid  <= valid_next;
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && write_here) begin
      pat <= ctl.char_value;
    end
  end

endmodule

FILE: tb/sv/wildcard_glob_matcher_tb.sv
// self-checking testbench for wildcard_glob_matcher: directed words, then random glob sessions
// depends on wgm_pkg and wildcard_glob_matcher; predicts every verdict with its own token row
`timescale 1ns / 1ps

module wildcard_glob_matcher_tb;
  import wgm_pkg::*;

  localparam int SOAK_WORDS     = 1700;  // random words after the directed part
  localparam int CALM_WORDS     = 250;   // closing stretch with no idling on either side
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES  = 16;    // a result shows up in the cycle after end of text

  // one input word as queued for the driver
  typedef struct packed {
    logic       drain;  // hold this word until every verdict is back
    func_t      func;
    logic [7:0] ch;
  } glob_word_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } glob_verdict_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] char_value
  logic [1:0] s_tuser = 2'b00;   // [1:0] func
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [0] matched, [1] pattern_overflow, [7:2] zero

  glob_word_t    words_pending[$];
  glob_verdict_t verdicts_due[$];

  // predicted matcher state
  logic [7:0]           pat_bytes [MAX_PATTERN];
  int                   pat_len;
  logic                 pat_ovf;
  logic [NUM_CELLS-1:0] tokens;

  logic       took_in = 1'b0;  // input word accepted at the last rising edge
  logic       calm = 1'b0;
  bit         drain_placed;
  int         gap_left;
  int         stall_left;
  int         idle_cycles;
  int         failures;
  glob_word_t next_word;

  wildcard_glob_matcher uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------- prediction

  // an active star also activates the position after it
  task automatic close_stars();
    int i;
    for (i = 0; i < pat_len; i++) begin
      if (tokens[i] && pat_bytes[i] == CHAR_ANY_RUN) tokens[i+1] = 1'b1;
    end
  endtask

  task automatic rearm_tokens();
    tokens    = '0;
    tokens[0] = 1'b1;
    close_stars();
  endtask

  task automatic glob_step(input func_t f, input logic [7:0] c);
    logic [NUM_CELLS-1:0] nxt;
    glob_verdict_t        v;
    int                   i;
    case (f)
      FUNC_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        rearm_tokens();
      end
      FUNC_APPEND: begin
        // past capacity the byte is lost and the overflow sticks until a clear
        if (pat_len < MAX_PATTERN) begin
          pat_bytes[pat_len] = c;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        rearm_tokens();
      end
      FUNC_TEXT: begin
        nxt = '0;
        for (i = 0; i < pat_len; i++) begin
          if (tokens[i]) begin
            if (pat_bytes[i] == CHAR_ANY_RUN) nxt[i] = 1'b1;
            else if (pat_bytes[i] == CHAR_ANY_ONE || pat_bytes[i] == c) nxt[i+1] = 1'b1;
          end
        end
        tokens = nxt;
        close_stars();
      end
      default: begin
        v.matched  = tokens[pat_len];
        v.overflow = pat_ovf;
        verdicts_due.push_back(v);
        rearm_tokens();
      end
    endcase
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    failures++;
    if (failures <= 10) $display("%0t: %s mismatch, expected %02h, got %02h", $realtime, what,
                                 want, got);
  endtask

  task automatic check_result(input logic [7:0] word);
    glob_verdict_t want;
    if (verdicts_due.size() == 0) begin
      failures++;
      if (failures <= 10) $display("%0t: result word %02h with no verdict outstanding",
                                   $realtime, word);
    end else begin
      want = verdicts_due.pop_front();
      if (word[0] !== want.matched) flag_mismatch("matched", {7'd0, want.matched}, {7'd0, word[0]});
      if (word[1] !== want.overflow)
        flag_mismatch("pattern_overflow", {7'd0, want.overflow}, {7'd0, word[1]});
      if (word[7:2] !== 6'd0) flag_mismatch("padding", 8'h00, {2'd0, word[7:2]});
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_word(input func_t f, input logic [7:0] c, input logic hold);
    glob_word_t w;
    w.drain = hold;
    w.func  = f;
    w.ch    = c;
    words_pending.push_back(w);
  endtask

  // mostly a narrow alphabet so literals hit, sometimes any byte
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0, 1:    return "a";
      2, 3:    return "b";
      4, 5:    return "c";
      6:       return "A";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    case ($urandom_range(0, 9))
      0, 1:    return CHAR_ANY_RUN;
      2:       return CHAR_ANY_ONE;
      default: return pick_text_byte();
    endcase
  endfunction

  // clear, load a pattern, then a few texts built to fit it, some of them spoiled
  task automatic add_session(input bit go_long);
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    logic       hold;
    int         plen, ntext, reps, j, k;
    hold = !drain_placed && words_pending.size() > 900;
    if (hold) drain_placed = 1'b1;
    if (go_long) plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
    else if ($urandom_range(0, 15) == 0) plen = $urandom_range(20, MAX_PATTERN + 3);
    else plen = $urandom_range(0, 8);
    add_word(FUNC_CLEAR, 8'($urandom_range(0, 255)), hold);
    for (k = 0; k < plen; k++) begin
      pat.push_back(pick_pattern_byte());
      add_word(FUNC_APPEND, pat[k], 1'b0);
    end
    ntext = $urandom_range(1, 4);
    for (j = 0; j < ntext; j++) begin
      txt.delete();
      // only the stored part of an overlong pattern takes part in matching
      for (k = 0; k < pat.size() && k < MAX_PATTERN; k++) begin
        if (pat[k] == CHAR_ANY_RUN) begin
          reps = $urandom_range(0, 3);
          repeat (reps) txt.push_back(pick_text_byte());
        end else if (pat[k] == CHAR_ANY_ONE) begin
          txt.push_back(pick_text_byte());
        end else begin
          txt.push_back(pat[k]);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, txt.size());
        case ($urandom_range(0, 2))
          0:       txt.insert(k, pick_text_byte());
          1:       if (k < txt.size()) txt.delete(k);
          default: if (k < txt.size()) txt[k] = pick_text_byte();
                   else txt.push_back(pick_text_byte());
        endcase
      end
      for (k = 0; k < txt.size(); k++) add_word(FUNC_TEXT, txt[k], 1'b0);
      add_word(FUNC_END, 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // raw words of any kind, appends onto an old pattern included
  task automatic add_noise();
    int n, k;
    n = $urandom_range(3, 10);
    for (k = 0; k < n; k++) add_word(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                     1'b0);
  endtask

  initial begin
    int directed_words;
    pat_len = 0;
    pat_ovf = 1'b0;
    foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
    rearm_tokens();

    // empty pattern: matches the empty text only
    add_word(FUNC_END,    8'h00, 1'b0);
    add_word(FUNC_TEXT,   8'hFF, 1'b0);
    add_word(FUNC_END,    8'h00, 1'b0);
    // lone star matches empty and non-empty text
    add_word(FUNC_CLEAR,  8'hFF, 1'b0);
    add_word(FUNC_APPEND, CHAR_ANY_RUN, 1'b0);
    add_word(FUNC_END,    8'h00, 1'b0);
    add_word(FUNC_TEXT,   8'h00, 1'b0);
    add_word(FUNC_END,    8'h00, 1'b0);
    // star then question mark: question mark past the end of text fails
    add_word(FUNC_APPEND, CHAR_ANY_ONE, 1'b0);
    add_word(FUNC_END,    8'h00, 1'b0);
    add_word(FUNC_TEXT,   "x", 1'b0);
    add_word(FUNC_TEXT,   "y", 1'b0);
    add_word(FUNC_END,    8'h00, 1'b0);
    // literals are case sensitive
    add_word(FUNC_CLEAR,  8'h00, 1'b0);
    add_word(FUNC_APPEND, "A", 1'b0);
    add_word(FUNC_APPEND, CHAR_ANY_ONE, 1'b0);
    add_word(FUNC_TEXT,   "a", 1'b0);
    add_word(FUNC_TEXT,   8'h80, 1'b0);
    add_word(FUNC_END,    8'h00, 1'b0);
    add_word(FUNC_TEXT,   "A", 1'b0);
    add_word(FUNC_TEXT,   8'h7F, 1'b0);
    add_word(FUNC_END,    8'h00, 1'b0);
    add_word(FUNC_CLEAR,  8'h55, 1'b0);
    directed_words = words_pending.size();

    // first random session always overflows the pattern store
    add_session(1'b1);
    while (words_pending.size() < directed_words + SOAK_WORDS) begin
      if ($urandom_range(0, 7) == 0) add_noise();
      else add_session(1'b0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_pending.size() != 0 || s_tvalid || verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      failures++;
      $display("%0d verdicts never arrived", verdicts_due.size());
    end
    if (failures == 0) begin
      $display("wildcard_glob_matcher regression: pass");
    end else begin
      $display("wildcard_glob_matcher regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  // a new word goes out once the previous one was taken, unless a gap or a drain hold applies
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || took_in)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (words_pending.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (words_pending[0].drain && verdicts_due.size() != 0) begin
        s_tvalid <= 1'b0;
      end else begin
        next_word = words_pending.pop_front();
        s_tdata  <= next_word.ch;
        s_tuser  <= next_word.func;
        s_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
      end
    end
    calm <= words_pending.size() < CALM_WORDS;
  end

  // result side backpressure in bursts
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    took_in <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) glob_step(func_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d cycles with no handshake", idle_cycles);
        $display("wildcard_glob_matcher regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
